// File: design/sfd_pkg.sv
package sfd_pkg;

   localparam logic [7:0] SYNC_FIRST = 8'hA5;
   localparam logic [7:0] SYNC_SECOND = 8'h5A;
   localparam logic [7:0] FRAME_VERSION = 8'h01;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam int unsigned POS_SYNC_FIRST = 0;
   localparam int unsigned POS_SYNC_SECOND = 1;
   localparam int unsigned POS_VERSION = 2;
   localparam int unsigned POS_OPCODE = 3;
   localparam int unsigned POS_SEQ_LOW = 4;
   localparam int unsigned POS_SEQ_HIGH = 5;
   localparam int unsigned POS_LEN_LOW = 6;
   localparam int unsigned POS_LEN_HIGH = 7;
   localparam int unsigned HDR_BYTES = 8;
   localparam int unsigned OVERHEAD = 10;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_LENGTH_ERROR = 2'd1;
   localparam logic [1:0] STATUS_HEADER_ERROR = 2'd2;
   localparam logic [1:0] STATUS_CRC_ERROR = 2'd3;

   localparam int unsigned LEN_OUT_W = 9;

   typedef struct packed {
      logic has_result;
      logic kind;
      logic [7:0] payload_data;
      logic [1:0] status;
      logic [7:0] frame_opcode;
      logic [15:0] frame_sequence;
      logic [LEN_OUT_W-1:0] frame_payload_length;
   } result_type;

endpackage

// File: design/sync_frame_crc16_decoder.sv
// Decodes sync-word framed packets (A5 5A, version 1, opcode, sequence, length, payload,
// CRC-16 with polynomial 1021 and initial value FFFF) arriving one byte per transaction,
// with req_end_of_frame marking the last byte of a frame. Payload bytes are forwarded
// provisionally as they arrive, and the marked byte produces a single status transaction
// after which all frame state returns to its reset value. The block accepts one byte every
// cycle unless the output register is stalled; a byte is captured in an input register,
// processed by the frame tracker and its combinational unrolled CRC byte update, and its
// result is loaded into the output register that drives rsp_valid. Bytes that produce no
// result (header, CRC and oversized payload bytes) are absorbed without output.
module sync_frame_crc16_decoder #(
   parameter int unsigned MAX_PAYLOAD = 256
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [7:0] req_data_byte,
   input logic req_end_of_frame,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic rsp_kind,
   output logic [7:0] rsp_payload_data,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_frame_opcode,
   output logic [15:0] rsp_frame_sequence,
   output logic [sfd_pkg::LEN_OUT_W-1:0] rsp_frame_payload_length
);

   logic in_valid_ff;
   logic [7:0] in_byte_ff;
   logic in_eof_ff;
   logic out_valid_ff;
   sfd_pkg::result_type out_ff;
   sfd_pkg::result_type result;
   logic out_free;
   logic step;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign step = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   sfd_frame_tracker #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_tracker (
      .clock (clock),
      .reset (reset),
      .step (step),
      .data_byte (in_byte_ff),
      .end_of_frame (in_eof_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_data_byte;
         in_eof_ff <= req_end_of_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= step && result.has_result;
      end
   end

   always_ff @(posedge clock) begin
      if (step && result.has_result) begin
         out_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_kind = out_ff.kind;
   assign rsp_payload_data = out_ff.payload_data;
   assign rsp_status = out_ff.status;
   assign rsp_frame_opcode = out_ff.frame_opcode;
   assign rsp_frame_sequence = out_ff.frame_sequence;
   assign rsp_frame_payload_length = out_ff.frame_payload_length;

`ifndef SYNTHESIS
   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the output register could advance");

   a_result_from_input: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(in_valid_ff))
      else $error("result appeared without a byte in the input register");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == sfd_pkg::KIND_STATUS) && (rsp_status != sfd_pkg::STATUS_OK))
      |-> ((rsp_frame_opcode == 8'h00) && (rsp_frame_sequence == 16'h0000) &&
           (rsp_frame_payload_length == '0)))
      else $error("frame fields reported with an error status");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == sfd_pkg::KIND_PAYLOAD)) |-> (rsp_status == sfd_pkg::STATUS_OK))
      else $error("payload transaction carries a status");
`endif

endmodule

// File: design/sfd_crc16.sv
module sfd_crc16 (
   input logic [15:0] crc_in,
   input logic [7:0] data_byte,
   output logic [15:0] crc_out
);

   always_comb begin
      logic [15:0] crc;
      crc = crc_in ^ {data_byte, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (crc[15]) begin
            crc = {crc[14:0], 1'b0} ^ sfd_pkg::CRC_POLY;
         end else begin
            crc = {crc[14:0], 1'b0};
         end
      end
      crc_out = crc;
   end

endmodule

// File: design/sfd_frame_tracker.sv
module sfd_frame_tracker #(
   parameter int unsigned MAX_PAYLOAD = 256
) (
   input logic clock,
   input logic reset,
   input logic step,
   input logic [7:0] data_byte,
   input logic end_of_frame,
   output sfd_pkg::result_type result
);

   localparam int unsigned CntW = $clog2(MAX_PAYLOAD + 12);
   localparam int unsigned CmpW = 18;
   localparam logic [CntW-1:0] CountSat = CntW'(MAX_PAYLOAD + 11);

   logic [CntW-1:0] count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic hdr_good_ff, hdr_good_in;
   logic [7:0] opcode_ff, opcode_in;
   logic [15:0] seq_ff, seq_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] rx_crc_ff, rx_crc_in;

   logic [15:0] crc_update;
   logic [CmpW-1:0] pos_wide;
   logic [CmpW-1:0] payload_end;
   logic crc_en;
   logic fwd;
   logic hdr_bad;
   logic [CntW-1:0] count_next;
   logic [1:0] status;

   sfd_crc16 u_crc (
      .crc_in (crc_ff),
      .data_byte (data_byte),
      .crc_out (crc_update)
   );

   always_comb begin
      pos_wide = CmpW'(count_ff);
      payload_end = CmpW'(sfd_pkg::HDR_BYTES) + CmpW'(len_ff);

      hdr_bad = ((count_ff == CntW'(sfd_pkg::POS_SYNC_FIRST)) &&
                 (data_byte != sfd_pkg::SYNC_FIRST)) ||
                ((count_ff == CntW'(sfd_pkg::POS_SYNC_SECOND)) &&
                 (data_byte != sfd_pkg::SYNC_SECOND)) ||
                ((count_ff == CntW'(sfd_pkg::POS_VERSION)) &&
                 (data_byte != sfd_pkg::FRAME_VERSION));
      hdr_good_in = hdr_good_ff && !hdr_bad;

      opcode_in = opcode_ff;
      seq_in = seq_ff;
      len_in = len_ff;
      rx_crc_in = rx_crc_ff;
      if (count_ff == CntW'(sfd_pkg::POS_OPCODE)) begin
         opcode_in = data_byte;
      end
      if (count_ff == CntW'(sfd_pkg::POS_SEQ_LOW)) begin
         seq_in = {seq_ff[15:8], data_byte};
      end
      if (count_ff == CntW'(sfd_pkg::POS_SEQ_HIGH)) begin
         seq_in = {data_byte, seq_ff[7:0]};
      end
      if (count_ff == CntW'(sfd_pkg::POS_LEN_LOW)) begin
         len_in = {len_ff[15:8], data_byte};
      end
      if (count_ff == CntW'(sfd_pkg::POS_LEN_HIGH)) begin
         len_in = {data_byte, len_ff[7:0]};
      end

      crc_en = (count_ff >= CntW'(sfd_pkg::POS_VERSION)) &&
               ((count_ff < CntW'(sfd_pkg::HDR_BYTES)) || (pos_wide < payload_end));
      crc_in = crc_en ? crc_update : crc_ff;

      fwd = (count_ff >= CntW'(sfd_pkg::HDR_BYTES)) && (pos_wide < payload_end) &&
            (CmpW'(len_ff) <= CmpW'(MAX_PAYLOAD));

      if ((count_ff >= CntW'(sfd_pkg::HDR_BYTES)) && (pos_wide == payload_end)) begin
         rx_crc_in = {rx_crc_ff[15:8], data_byte};
      end
      if ((count_ff >= CntW'(sfd_pkg::HDR_BYTES)) &&
          (pos_wide == payload_end + CmpW'(1))) begin
         rx_crc_in = {data_byte, rx_crc_ff[7:0]};
      end

      count_next = (count_ff < CountSat) ? count_ff + CntW'(1) : count_ff;
      count_in = count_next;

      if (count_next < CntW'(sfd_pkg::OVERHEAD)) begin
         status = sfd_pkg::STATUS_LENGTH_ERROR;
      end else if (!hdr_good_in) begin
         status = sfd_pkg::STATUS_HEADER_ERROR;
      end else if ((CmpW'(len_in) > CmpW'(MAX_PAYLOAD)) ||
                   (CmpW'(count_next) != CmpW'(len_in) + CmpW'(sfd_pkg::OVERHEAD))) begin
         status = sfd_pkg::STATUS_LENGTH_ERROR;
      end else if (rx_crc_in != crc_in) begin
         status = sfd_pkg::STATUS_CRC_ERROR;
      end else begin
         status = sfd_pkg::STATUS_OK;
      end

      result = '0;
      result.has_result = end_of_frame || fwd;
      if (end_of_frame) begin
         result.kind = sfd_pkg::KIND_STATUS;
         result.status = status;
         if (status == sfd_pkg::STATUS_OK) begin
            result.frame_opcode = opcode_in;
            result.frame_sequence = seq_in;
            result.frame_payload_length = len_in[sfd_pkg::LEN_OUT_W-1:0];
         end
      end else begin
         result.kind = sfd_pkg::KIND_PAYLOAD;
         result.payload_data = fwd ? data_byte : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         crc_ff <= sfd_pkg::CRC_INIT;
         hdr_good_ff <= 1'b1;
         opcode_ff <= '0;
         seq_ff <= '0;
         len_ff <= '0;
         rx_crc_ff <= '0;
      end else if (step) begin
         if (end_of_frame) begin
            count_ff <= '0;
            crc_ff <= sfd_pkg::CRC_INIT;
            hdr_good_ff <= 1'b1;
            opcode_ff <= '0;
            seq_ff <= '0;
            len_ff <= '0;
            rx_crc_ff <= '0;
         end else begin
            count_ff <= count_in;
            crc_ff <= crc_in;
            hdr_good_ff <= hdr_good_in;
            opcode_ff <= opcode_in;
            seq_ff <= seq_in;
            len_ff <= len_in;
            rx_crc_ff <= rx_crc_in;
         end
      end
   end

endmodule
